@@ sv/xypm_pkg.sv @@
// Shared types and constants for the XY position PID omni mixer.
package xypm_pkg;

  localparam int FRAC_BITS = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [2:0] REG_INTEG_STEP  = 3'd3;
  localparam logic [2:0] REG_DERIV_SCALE = 3'd4;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;
  localparam logic [2:0] REG_POWER_LIMIT = 3'd6;

  localparam logic signed [15:0] PREV_ERR_X_RST = 16'sd61;
  localparam logic signed [15:0] PREV_ERR_Y_RST = 16'sd22;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input transfer, form errors
    logic upd;       // update integral and derivative for both axes
    logic drive;     // compute drives
    logic mix;       // mix, round, saturate, find max
    logic div_start; // start rescale divider for one wheel
    logic div_step;  // one divider bit step
    logic div_done;  // write divider quotient back
    logic [1:0] wheel;
  } xypm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic tick_new;
    logic need_scale;
  } xypm_sts_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_UPD   = 8'b00000010,
    ST_DRIVE = 8'b00000100,
    ST_MIX   = 8'b00001000,
    ST_DSTRT = 8'b00010000,
    ST_DIV   = 8'b00100000,
    ST_DWR   = 8'b01000000,
    ST_OUT   = 8'b10000000
  } xypm_state_t;

endpackage

@@ sv/xypm_datapath.sv @@
// Datapath: error, integral, derivative, drive, mix and rescale divider.
module xypm_datapath import xypm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  xypm_cmd_t          cmd,
  output xypm_sts_t          sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_measured_x,
  input  logic signed [15:0] in_measured_y,
  input  logic [7:0]         in_tick_count,
  output logic signed [15:0] w0,
  output logic signed [15:0] w1,
  output logic signed [15:0] w2,
  output logic signed [15:0] w3
);

  // Configuration registers
  logic [15:0] kp_r, ki_r, kd_r, is_r, ds_r;
  logic [22:0] il_r;
  logic [14:0] pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 16'd256; ki_r <= 16'd0; kd_r <= 16'd0;
      is_r <= 16'd256; ds_r <= 16'd256;
      il_r <= 23'h7FFFFF; pl_r <= 15'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_PROP:   kp_r <= cfg_data[15:0];
        REG_GAIN_INTEG:  ki_r <= cfg_data[15:0];
        REG_GAIN_DERIV:  kd_r <= cfg_data[15:0];
        REG_INTEG_STEP:  is_r <= cfg_data[15:0];
        REG_DERIV_SCALE: ds_r <= cfg_data[15:0];
        REG_INTEG_LIMIT: il_r <= cfg_data;
        REG_POWER_LIMIT: pl_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Persistent state
  logic [7:0]         last_tick_r;
  logic signed [31:0] integ_x_r, integ_y_r;
  logic signed [15:0] prev_x_r, prev_y_r;
  // Per-item registers
  logic signed [15:0] ex_r, ey_r;
  logic [7:0]         tick_r;
  logic signed [33:0] dx_r, dy_r;
  logic signed [57:0] drv_x_r, drv_y_r;
  logic signed [15:0] w_r [4];
  logic [15:0]        max_r;

  assign sts.tick_new   = tick_r != last_tick_r;
  assign sts.need_scale = max_r > {1'b0, pl_r};

  // Integral update per axis
  function automatic logic signed [31:0] integ_next(logic signed [15:0] e,
      logic signed [31:0] i, logic [15:0] s, logic [22:0] lim);
    logic signed [49:0] acc;
    logic signed [49:0] l;
    begin
      l   = $signed({27'd0, lim});
      acc = 50'(i) + 50'(e * $signed({1'b0, s}));
      if (acc > l) acc = l;
      else if (acc < -l) acc = -l;
      if (e == 0 || (e > 0 && acc <= 0) || (e < 0 && acc >= 0)) acc = '0;
      integ_next = acc[31:0];
    end
  endfunction

  // Drive: P<<F + I*ki + D*kd
  function automatic logic signed [57:0] drive_of(logic signed [15:0] e,
      logic signed [31:0] i, logic signed [33:0] d,
      logic [15:0] p, logic [15:0] ki, logic [15:0] kd);
    logic signed [57:0] tp, ti, td;
    begin
      tp = 58'(e * $signed({1'b0, p})) <<< FRAC_BITS;
      ti = 58'(i * $signed({1'b0, ki}));
      td = 58'(d * $signed({1'b0, kd}));
      drive_of = tp + ti + td;
    end
  endfunction

  function automatic logic signed [15:0] round_sat(logic signed [59:0] v);
    logic [59:0] m, r;
    begin
      m = v[59] ? 60'(-v) : 60'(v);
      r = (m + (60'd1 << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
      if (v[59]) round_sat = (r > 60'd32768) ? -16'sd32768 : 16'(-r);
      else       round_sat = (r > 60'd32767) ? 16'sd32767 : r[15:0];
    end
  endfunction

  // Mixing values
  logic signed [59:0] mixv [4];
  logic signed [15:0] wm [4];
  logic [15:0] mag [4];
  logic [15:0] mx01, mx23;
  always_comb begin
    mixv[0] =  60'(drv_x_r) - 60'(drv_y_r);
    mixv[1] = -60'(drv_x_r) - 60'(drv_y_r);
    mixv[2] = -60'(drv_x_r) + 60'(drv_y_r);
    mixv[3] =  60'(drv_x_r) + 60'(drv_y_r);
    for (int k = 0; k < 4; k++) begin
      wm[k]  = round_sat(mixv[k]);
      mag[k] = wm[k][15] ? 16'(-wm[k]) : 16'(wm[k]);
    end
    mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
  end

  // Restoring divider: q = (2*m*pl + M) / (2*M)
  logic [32:0] rem_r, num_r;
  logic [31:0] q_r;
  logic        dneg_r;
  logic [32:0] dden;
  logic [32:0] rtry;
  logic [15:0] cur_w, cur_m;
  assign cur_w = w_r[cmd.wheel];
  assign cur_m = cur_w[15] ? 16'(-cur_w) : cur_w;
  assign dden  = {16'd0, max_r, 1'b0};
  assign rtry  = {rem_r[31:0], num_r[32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
      integ_x_r <= '0; integ_y_r <= '0;
      prev_x_r <= PREV_ERR_X_RST; prev_y_r <= PREV_ERR_Y_RST;
    end else if (cmd.upd) begin
      integ_x_r <= integ_next(ex_r, integ_x_r, is_r, il_r);
      integ_y_r <= integ_next(ey_r, integ_y_r, is_r, il_r);
      prev_x_r <= ex_r; prev_y_r <= ey_r;
      last_tick_r <= tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ex_r   <= 16'(in_measured_x - in_target_x);
      ey_r   <= 16'(in_measured_y - in_target_y);
      tick_r <= in_tick_count;
      dx_r   <= '0; dy_r <= '0;
    end
    if (cmd.upd) begin
      dx_r <= (34'(ex_r) - 34'(prev_x_r)) * $signed({18'd0, ds_r});
      dy_r <= (34'(ey_r) - 34'(prev_y_r)) * $signed({18'd0, ds_r});
    end
    if (cmd.drive) begin
      drv_x_r <= drive_of(ex_r, integ_x_r, dx_r, kp_r, ki_r, kd_r);
      drv_y_r <= drive_of(ey_r, integ_y_r, dy_r, kp_r, ki_r, kd_r);
    end
    if (cmd.mix) begin
      for (int k = 0; k < 4; k++) w_r[k] <= wm[k];
      max_r <= (mx01 > mx23) ? mx01 : mx23;
    end
    if (cmd.div_start) begin
      num_r  <= 33'({cur_m, 1'b0} * pl_r) + 33'(max_r);
      rem_r  <= '0;
      q_r    <= '0;
      dneg_r <= cur_w[15];
    end
    if (cmd.div_step) begin
      num_r  <= {num_r[31:0], 1'b0};
      if (rtry >= dden) begin
        rem_r <= rtry - dden;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= rtry;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
    if (cmd.div_done) w_r[cmd.wheel] <= dneg_r ? 16'(-q_r) : q_r[15:0];
  end

  assign w0 = w_r[0];
  assign w1 = w_r[1];
  assign w2 = w_r[2];
  assign w3 = w_r[3];

endmodule

@@ sv/xypm_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
module xypm_ctrl import xypm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  xypm_sts_t sts,
  output xypm_cmd_t cmd
);

  xypm_state_t state_r, state_nxt;
  logic [1:0] wheel_r, wheel_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_OUT;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    wheel_nxt = wheel_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.wheel = wheel_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = sts.tick_new;
        state_nxt = ST_DRIVE;
      end
      ST_DRIVE: begin
        cmd.drive = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix = 1'b1;
        wheel_nxt = '0;
        state_nxt = ST_DSTRT;
      end
      ST_DSTRT: begin
        if (sts.need_scale) begin
          cmd.div_start = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd32) state_nxt = ST_DWR;
      end
      ST_DWR: begin
        cmd.div_done = 1'b1;
        wheel_nxt = wheel_r + 2'd1;
        state_nxt = (wheel_r == 2'd3) ? ST_OUT : ST_DSTRT;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wheel_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wheel_r <= wheel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/xy_position_pid_omni_mixer.sv @@
// Top level: XY position PID with four-wheel omni mixing.
// One item at a time: a new input is taken only while idle. When the largest wheel
// magnitude exceeds power_limit, a shared bit-serial divider rescales the four wheels one
// after another (start, 33 quotient bits, write back). Stalls on out_ready hold the result
// until it is taken. Configuration must be written only while idle through
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this.
module xy_position_pid_omni_mixer import xypm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_measured_x,
  input  logic signed [15:0] in_measured_y,
  input  logic [7:0]         in_tick_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_wheel_power_0,
  output logic signed [15:0] out_wheel_power_1,
  output logic signed [15:0] out_wheel_power_2,
  output logic signed [15:0] out_wheel_power_3
);

  xypm_cmd_t cmd;
  xypm_sts_t sts;

  xypm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  xypm_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_target_x, .in_target_y, .in_measured_x, .in_measured_y, .in_tick_count,
    .w0(out_wheel_power_0), .w1(out_wheel_power_1),
    .w2(out_wheel_power_2), .w3(out_wheel_power_3)
  );

endmodule

@@ tb/xy_position_pid_omni_mixer_tb.sv @@
// Testbench for the XY position PID omni mixer: random and directed positions, checked
// against a cycle-free predictor.
module xy_position_pid_omni_mixer_tb;
  import xypm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 160;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [7:0]         tick;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] p0;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
  } wheels_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [22:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_target_x, in_target_y, in_measured_x, in_measured_y;
  logic [7:0] in_tick_count;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_wheel_power_0, out_wheel_power_1;
  logic signed [15:0] out_wheel_power_2, out_wheel_power_3;

  always #1 clk = ~clk;

  xy_position_pid_omni_mixer u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_measured_x(in_measured_x), .in_measured_y(in_measured_y),
    .in_tick_count(in_tick_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_wheel_power_0(out_wheel_power_0), .out_wheel_power_1(out_wheel_power_1),
    .out_wheel_power_2(out_wheel_power_2), .out_wheel_power_3(out_wheel_power_3)
  );

  // Controller model: configuration mirror and loop state
  longint gain_p, gain_i, gain_d, integ_step, deriv_step, integ_lim, power_lim;
  logic [7:0] seen_tick;
  longint integ_x, integ_y;
  logic signed [15:0] prev_ex, prev_ey;

  wheels_t wheel_q[$];
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int cyc = 0;
  int burst_left = 0;
  bit no_idle = 0;
  logic [7:0] tick_sent = 8'd0;

  // Integral clamp/reset and derivative for one axis
  function automatic longint axis_step(input logic signed [15:0] err, inout longint integ,
                                       inout logic signed [15:0] prev);
    longint acc;
    longint e;
    e = longint'(err);
    acc = integ + e * integ_step;
    if (acc > integ_lim) acc = integ_lim;
    else if (acc < -integ_lim) acc = -integ_lim;
    if (e == 0 || (e > 0 && acc <= 0) || (e < 0 && acc >= 0)) acc = 0;
    integ = acc;
    axis_step = (e - longint'(prev)) * deriv_step;
    prev = err;
  endfunction

  function automatic longint axis_drive(input logic signed [15:0] err, input longint integ,
                                        input longint deriv);
    return longint'(err) * gain_p * 256 + integ * gain_i + deriv * gain_d;
  endfunction

  // Round half away from zero, then saturate to 16 bits
  function automatic longint round_clip(input longint v);
    longint m, r;
    m = (v < 0) ? -v : v;
    r = (m + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    if (v < 0) return (r > 32768) ? -32768 : -r;
    return (r > 32767) ? 32767 : r;
  endfunction

  task automatic predict_wheels(input sample_t s);
    logic signed [15:0] ex, ey;
    longint dx, dy, drv_x, drv_y, maxmag, m;
    longint w[4];
    wheels_t res;
    ex = s.mx - s.tx;
    ey = s.my - s.ty;
    dx = 0;
    dy = 0;
    if (s.tick != seen_tick) begin
      dx = axis_step(ex, integ_x, prev_ex);
      dy = axis_step(ey, integ_y, prev_ey);
      seen_tick = s.tick;
    end
    drv_x = axis_drive(ex, integ_x, dx);
    drv_y = axis_drive(ey, integ_y, dy);
    w[0] = round_clip(drv_x - drv_y);
    w[1] = round_clip(-drv_x - drv_y);
    w[2] = round_clip(-drv_x + drv_y);
    w[3] = round_clip(drv_x + drv_y);
    maxmag = 0;
    foreach (w[i]) begin
      m = (w[i] < 0) ? -w[i] : w[i];
      if (m > maxmag) maxmag = m;
    end
    // common rescale when over the power limit
    if (maxmag > power_lim) begin
      foreach (w[i]) begin
        m = (w[i] < 0) ? -w[i] : w[i];
        m = (2 * m * power_lim + maxmag) / (2 * maxmag);
        w[i] = (w[i] < 0) ? -m : m;
      end
    end
    res.p0 = 16'(w[0]);
    res.p1 = 16'(w[1]);
    res.p2 = 16'(w[2]);
    res.p3 = 16'(w[3]);
    wheel_q.push_back(res);
  endtask

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cyc, what);
    err_count++;
  endtask

  // Result checking and receiver stall pattern
  always @(posedge clk) begin
    wheels_t exp_w;
    cyc <= cyc + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (wheel_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        exp_w = wheel_q.pop_front();
        if (out_wheel_power_0 !== exp_w.p0)
          report($sformatf("wheel 0 got %0d want %0d", out_wheel_power_0, exp_w.p0));
        if (out_wheel_power_1 !== exp_w.p1)
          report($sformatf("wheel 1 got %0d want %0d", out_wheel_power_1, exp_w.p1));
        if (out_wheel_power_2 !== exp_w.p2)
          report($sformatf("wheel 2 got %0d want %0d", out_wheel_power_2, exp_w.p2));
        if (out_wheel_power_3 !== exp_w.p3)
          report($sformatf("wheel 3 got %0d want %0d", out_wheel_power_3, exp_w.p3));
      end
    end
    case (cyc[12:11])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (cyc[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("xy_position_pid_omni_mixer_tb: errors");
      $finish;
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    in_valid <= 1'b1;
    in_target_x <= s.tx;
    in_target_y <= s.ty;
    in_measured_x <= s.mx;
    in_measured_y <= s.my;
    in_tick_count <= s.tick;
    do @(posedge clk); while (!in_ready);
    predict_wheels(s);
    items_sent++;
    tick_sent = s.tick;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!no_idle) gap = $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pos(input int tx, input int ty, input int mx, input int my,
                          input int tick);
    sample_t s;
    s.tx = 16'(tx);
    s.ty = 16'(ty);
    s.mx = 16'(mx);
    s.my = 16'(my);
    s.tick = 8'(tick);
    send_sample(s);
  endtask

  // Mostly advancing ticks with errors near zero; some full-range noise
  function automatic sample_t rand_sample();
    sample_t s;
    int r;
    s.tx = 16'($urandom);
    s.ty = 16'($urandom);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      s.mx = 16'(s.tx + $urandom_range(0, 400) - 200);
      s.my = 16'(s.ty + $urandom_range(0, 400) - 200);
    end else if (r < 8) begin
      s.mx = 16'(s.tx + $urandom_range(0, 8000) - 4000);
      s.my = 16'(s.ty + $urandom_range(0, 8000) - 4000);
    end else begin
      s.mx = 16'($urandom);
      s.my = 16'($urandom);
    end
    r = $urandom_range(0, 19);
    if (r < 14) s.tick = tick_sent + 8'd1;
    else if (r < 17) s.tick = tick_sent;
    else s.tick = 8'($urandom);
    return s;
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GAIN_PROP:   gain_p = longint'(val[15:0]);
      REG_GAIN_INTEG:  gain_i = longint'(val[15:0]);
      REG_GAIN_DERIV:  gain_d = longint'(val[15:0]);
      REG_INTEG_STEP:  integ_step = longint'(val[15:0]);
      REG_DERIV_SCALE: deriv_step = longint'(val[15:0]);
      REG_INTEG_LIMIT: integ_lim = longint'(val[22:0]);
      REG_POWER_LIMIT: power_lim = longint'(val[14:0]);
      default: ;
    endcase
  endtask

  task automatic cfg_all(input int gp, input int gi, input int gd, input int is,
                         input int ds, input int il, input int pl);
    wait_idle();
    cfg_write(REG_GAIN_PROP, 23'(gp));
    cfg_write(REG_GAIN_INTEG, 23'(gi));
    cfg_write(REG_GAIN_DERIV, 23'(gd));
    cfg_write(REG_INTEG_STEP, 23'(is));
    cfg_write(REG_DERIV_SCALE, 23'(ds));
    cfg_write(REG_INTEG_LIMIT, 23'(il));
    cfg_write(REG_POWER_LIMIT, 23'(pl));
  endtask

  task automatic run_random(input int n);
    repeat (n) send_sample(rand_sample());
  endtask

  // Reset values, error wrap, held tick, zero error, sign flip on integral
  task automatic test_directed();
    send_pos(0, 0, 0, 0, 0);
    send_pos(0, 0, 0, 0, 1);
    send_pos(-32768, 32767, 32767, -32768, 2);
    send_pos(32767, -32768, -32768, 32767, 3);
    send_pos(-32768, 32767, 0, -1, 4);
    send_pos(-1, -1, -1, -1, 4);
    send_pos(16'h5555, 16'h2aaa, 16'h2aaa, 16'h5555, 5);
    cfg_all(256, 512, 256, 256, 256, 3000, 1000);
    cfg_write(REG_UNUSED, 23'h7fffff);
    send_pos(0, 0, 10, -10, 6);
    send_pos(0, 0, 12, -8, 7);
    send_pos(0, 0, 12, -8, 7);
    send_pos(0, 0, -3, 4, 8);
    send_pos(0, 0, 40, 40, 9);
    send_pos(0, 0, 40, 40, 255);
    send_pos(0, 0, 0, 0, 0);
    send_pos(100, -100, 200, -200, 1);
  endtask

  task automatic test_default_gains();
    cfg_all(256, 0, 0, 256, 256, 8388607, 1000);
    run_random(300);
  endtask

  task automatic test_full_pid();
    cfg_all(128, 64, 32, 200, 300, 20000, 2000);
    run_random(300);
    cfg_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(250);
  endtask

  task automatic test_extreme_cfg();
    cfg_all(65535, 65535, 65535, 65535, 65535, 8388607, 32767);
    run_random(250);
    no_idle = 1;
    cfg_all(0, 0, 0, 0, 0, 0, 0);
    run_random(100);
    no_idle = 0;
  endtask

  task automatic test_small_limits();
    cfg_all(8, 4, 2, 16, 16, 500, 1);
    run_random(200);
    cfg_all(300, 20, 10, 64, 512, 100000, 32767);
    run_random(350);
  endtask

  initial begin
    gain_p = 256; gain_i = 0; gain_d = 0;
    integ_step = 256; deriv_step = 256;
    integ_lim = 8388607; power_lim = 1000;
    seen_tick = 8'd0;
    integ_x = 0; integ_y = 0;
    prev_ex = PREV_ERR_X_RST;
    prev_ey = PREV_ERR_Y_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_target_x = '0;
    in_target_y = '0;
    in_measured_x = '0;
    in_measured_y = '0;
    in_tick_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_default_gains();
    test_full_pid();
    test_extreme_cfg();
    test_small_limits();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wheel_q.size() != 0) report($sformatf("%0d results never came", wheel_q.size()));
    $display("Sent %0d position samples, checked %0d wheel power results,", items_sent,
             results_seen);
    $display("over default, full PID, extreme, zero and tight-limit settings.");
    if (err_count == 0) begin
      $display("xy_position_pid_omni_mixer_tb: clean");
    end else begin
      $display("xy_position_pid_omni_mixer_tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/xypm_pkg.sv
sv/xypm_datapath.sv
sv/xypm_ctrl.sv
sv/xy_position_pid_omni_mixer.sv
tb/xy_position_pid_omni_mixer_tb.sv
